FILE: rtl/core/joystick_deadzone_normalizer_unit_macros.svh
// Assertion macros for the checker of the joystick normaliser.
`ifndef JOYSTICK_DEADZONE_NORMALIZER_UNIT_MACROS_SVH
`define JOYSTICK_DEADZONE_NORMALIZER_UNIT_MACROS_SVH

// Same-cycle implication, switched off while rst is high.
`define JDN_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jdn assertion failed");

// Next-cycle implication, switched off while rst is high.
`define JDN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jdn assertion failed");

`endif

FILE: rtl/core/jdn_pkg.sv
`default_nettype none

package jdn_pkg;

   // Fixed field widths.
   localparam int SAMPLE_W   = 12;
   localparam int DZ_W       = 8;
   localparam int POS_W      = 16;
   localparam int Q_W        = 16;
   localparam int LANES      = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [SAMPLE_W-1:0] CENTER_RESET = 12'd2048;
   localparam logic [POS_W-1:0]    POS_LIMIT    = 16'd32767;

   // Lane numbering.
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_CENTER_X   = 3'd0,
      REG_CENTER_Y   = 3'd1,
      REG_DEADZONE_X = 3'd2,
      REG_DEADZONE_Y = 3'd3,
      REG_FLIP_X     = 3'd4,
      REG_FLIP_Y     = 3'd5
   } reg_idx_type;

   // Per-item control that travels alongside the division chain.
   typedef struct packed {
      logic [LANES-1:0] zero;
      logic [LANES-1:0] neg;
      logic             fault;
   } ctl_type;

endpackage

`default_nettype wire

FILE: rtl/core/jdn_prep.sv
`default_nettype none

module jdn_prep
   import jdn_pkg::*;
#(
   parameter int FULL_SCALE = 4095,
   parameter int FRAC_BITS  = 15,
   parameter int DIV_W      = 12,
   parameter int DVD_W      = 27
) (
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [SAMPLE_W-1:0] center,
   input  logic [DZ_W-1:0]     deadzone,
   input  logic                flip,
   output logic                zero,
   output logic                neg,
   output logic                fault,
   output logic [DVD_W-1:0]    dvd,
   output logic [DIV_W-1:0]    div
);

   localparam int OFF_W = SAMPLE_W + 2;
   localparam int SP_W  = DIV_W + 2;

   logic signed [OFF_W-1:0] off_w;
   logic signed [OFF_W-1:0] dz_w;
   logic        [OFF_W-1:0] mag_w;
   logic                    inside_w;
   logic                    below_w;
   logic signed [SP_W-1:0]  span_w;
   logic                    bad_w;

   // Offset from the centre and the deadzone band test.
   always_comb begin
      off_w    = $signed({2'b00, sample}) - $signed({2'b00, center});
      dz_w     = $signed({{(OFF_W-DZ_W){1'b0}}, deadzone});
      inside_w = (off_w >= -dz_w) && (off_w <= dz_w);
      below_w  = off_w[OFF_W-1];
      mag_w    = below_w ? OFF_W'(-off_w - dz_w) : OFF_W'(off_w - dz_w);
   end

   // Span on the side of the centre that the sample lies on.
   always_comb begin
      if (below_w) begin
         span_w = SP_W'(center) - SP_W'(deadzone);
      end else begin
         span_w = SP_W'(FULL_SCALE) - SP_W'(center) - SP_W'(deadzone);
      end
      bad_w = span_w[SP_W-1] || (span_w == '0);
   end

   // Dividend is the magnitude times (2^FRAC_BITS - 1).
   assign dvd   = (DVD_W'(mag_w[SAMPLE_W-1:0]) << FRAC_BITS)
                  - DVD_W'(mag_w[SAMPLE_W-1:0]);
   assign div   = span_w[DIV_W-1:0];
   assign zero  = inside_w || bad_w;
   assign fault = !inside_w && bad_w;
   assign neg   = below_w ^ flip;

endmodule

`default_nettype wire

FILE: rtl/core/jdn_div_cell.sv
`default_nettype none

module jdn_div_cell
   import jdn_pkg::*;
#(
   parameter int DIV_W   = 12,
   parameter int DVD_W   = 27,
   parameter int BIT_POS = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  ctl_type                     up_ctl,
   input  logic [LANES-1:0][DVD_W-1:0] up_rem,
   input  logic [LANES-1:0][DIV_W-1:0] up_div,
   input  logic [LANES-1:0][Q_W-1:0]   up_quo,
   output logic                        dn_valid,
   input  logic                        dn_ready,
   output ctl_type                     dn_ctl,
   output logic [LANES-1:0][DVD_W-1:0] dn_rem,
   output logic [LANES-1:0][DIV_W-1:0] dn_div,
   output logic [LANES-1:0][Q_W-1:0]   dn_quo
);

   localparam int CMP_W = (DVD_W > DIV_W + Q_W) ? DVD_W : DIV_W + Q_W;

   logic                        valid_ff;
   logic                        valid_in;
   ctl_type                     ctl_ff;
   logic [LANES-1:0][DVD_W-1:0] rem_ff;
   logic [LANES-1:0][DVD_W-1:0] rem_in;
   logic [LANES-1:0][DIV_W-1:0] div_ff;
   logic [LANES-1:0][Q_W-1:0]   quo_ff;
   logic [LANES-1:0][Q_W-1:0]   quo_in;
   logic [LANES-1:0][CMP_W-1:0] shifted_w;
   logic [LANES-1:0][CMP_W-1:0] diff_w;
   logic [LANES-1:0]            take_w;

   // One restoring step per lane: resolve quotient bit BIT_POS.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         shifted_w[l] = CMP_W'(up_div[l]) << BIT_POS;
         take_w[l]    = CMP_W'(up_rem[l]) >= shifted_w[l];
         diff_w[l]    = CMP_W'(up_rem[l]) - shifted_w[l];
         rem_in[l]    = take_w[l] ? diff_w[l][DVD_W-1:0] : up_rem[l];
         quo_in[l]    = up_quo[l] | (Q_W'(take_w[l]) << BIT_POS);
      end
   end

   // The cell takes an item whenever it is empty or its neighbour takes its own.
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         ctl_ff <= up_ctl;
         rem_ff <= rem_in;
         div_ff <= up_div;
         quo_ff <= quo_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_ctl   = ctl_ff;
   assign dn_rem   = rem_ff;
   assign dn_div   = div_ff;
   assign dn_quo   = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/core/jdn_post.sv
`default_nettype none

module jdn_post
   import jdn_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  ctl_type                   up_ctl,
   input  logic [LANES-1:0][Q_W-1:0] up_quo,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [POS_W-1:0]   rsp_pos_x,
   output logic signed [POS_W-1:0]   rsp_pos_y,
   output logic                      rsp_span_fault
);

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [LANES-1:0][POS_W-1:0] pos_ff;
   logic [LANES-1:0][POS_W-1:0] pos_in;
   logic                        fault_ff;
   logic [LANES-1:0][POS_W-1:0] mag_w;

   // Saturate the quotient, then apply sign and the forced zero.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mag_w[l] = up_quo[l][Q_W-1] ? POS_LIMIT : {1'b0, up_quo[l][Q_W-2:0]};
         if (up_ctl.zero[l]) begin
            pos_in[l] = '0;
         end else if (up_ctl.neg[l]) begin
            pos_in[l] = -mag_w[l];
         end else begin
            pos_in[l] = mag_w[l];
         end
      end
   end

   // Output register: loads when empty or when the receiver takes the item.
   assign up_ready     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = up_ready ? up_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         pos_ff   <= pos_in;
         fault_ff <= up_ctl.fault;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = $signed(pos_ff[LANE_X]);
   assign rsp_pos_y      = $signed(pos_ff[LANE_Y]);
   assign rsp_span_fault = fault_ff;

endmodule

`default_nettype wire

FILE: rtl/core/joystick_deadzone_normalizer_unit.sv
// Joystick deadzone normaliser.
// An item on the req_ channel is one pair of raw ADC codes (X and Y). Each
// axis has its centre removed, a deadzone applied and is divided by the span
// on its side of the centre, giving a signed Q1.15 position saturated to
// +-32767; rsp_span_fault flags a span <= 0 on an axis past its deadzone.
// Both channels are valid/ready. The csr_ port writes the centres, deadzone
// half widths and flip bits, and should only be used while no item is in
// flight.
// Throughput is one item per cycle while the receiver keeps up. The input
// stage takes the item at the accepting edge; it then passes through the
// 16 divider cells (one quotient bit for both axes) and the output register,
// which drives rsp_valid.
// When the receiver stalls, items keep entering until every stage of the
// chain holds one, then req_ready falls; nothing is dropped.
// Reset empties the chain and restores the register defaults (centre 2048,
// no deadzone, no flip).

`default_nettype none

module joystick_deadzone_normalizer_unit
   import jdn_pkg::*;
#(
   parameter int FULL_SCALE = 4095,
   parameter int FRAC_BITS  = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_W-1:0]     req_sample_x,
   input  logic [SAMPLE_W-1:0]     req_sample_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [POS_W-1:0] rsp_pos_x,
   output logic signed [POS_W-1:0] rsp_pos_y,
   output logic                    rsp_span_fault,
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DIV_W     = (FULL_SCALE >= (1 << SAMPLE_W)) ?
                              $clog2(FULL_SCALE + 1) : SAMPLE_W;
   localparam int DVD_W     = SAMPLE_W + FRAC_BITS;
   localparam int NUM_CELLS = Q_W;

   // Configuration registers.
   logic [SAMPLE_W-1:0] center_x_ff;
   logic [SAMPLE_W-1:0] center_y_ff;
   logic [DZ_W-1:0]     deadzone_x_ff;
   logic [DZ_W-1:0]     deadzone_y_ff;
   logic                flip_x_ff;
   logic                flip_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= CENTER_RESET;
         center_y_ff   <= CENTER_RESET;
         deadzone_x_ff <= '0;
         deadzone_y_ff <= '0;
         flip_x_ff     <= 1'b0;
         flip_y_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_CENTER_X:   center_x_ff   <= csr_wdata[SAMPLE_W-1:0];
            REG_CENTER_Y:   center_y_ff   <= csr_wdata[SAMPLE_W-1:0];
            REG_DEADZONE_X: deadzone_x_ff <= csr_wdata[DZ_W-1:0];
            REG_DEADZONE_Y: deadzone_y_ff <= csr_wdata[DZ_W-1:0];
            REG_FLIP_X:     flip_x_ff     <= csr_wdata[0];
            REG_FLIP_Y:     flip_y_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Per-axis offset, deadzone and span.
   logic [LANES-1:0]            prep_zero;
   logic [LANES-1:0]            prep_neg;
   logic [LANES-1:0]            prep_fault;
   logic [LANES-1:0][DVD_W-1:0] prep_dvd;
   logic [LANES-1:0][DIV_W-1:0] prep_div;

   jdn_prep #(
      .FULL_SCALE (FULL_SCALE),
      .FRAC_BITS  (FRAC_BITS),
      .DIV_W      (DIV_W),
      .DVD_W      (DVD_W)
   ) u_prep_x (
      .sample   (req_sample_x),
      .center   (center_x_ff),
      .deadzone (deadzone_x_ff),
      .flip     (flip_x_ff),
      .zero     (prep_zero[LANE_X]),
      .neg      (prep_neg[LANE_X]),
      .fault    (prep_fault[LANE_X]),
      .dvd      (prep_dvd[LANE_X]),
      .div      (prep_div[LANE_X])
   );

   jdn_prep #(
      .FULL_SCALE (FULL_SCALE),
      .FRAC_BITS  (FRAC_BITS),
      .DIV_W      (DIV_W),
      .DVD_W      (DVD_W)
   ) u_prep_y (
      .sample   (req_sample_y),
      .center   (center_y_ff),
      .deadzone (deadzone_y_ff),
      .flip     (flip_y_ff),
      .zero     (prep_zero[LANE_Y]),
      .neg      (prep_neg[LANE_Y]),
      .fault    (prep_fault[LANE_Y]),
      .dvd      (prep_dvd[LANE_Y]),
      .div      (prep_div[LANE_Y])
   );

   // Links of the chain; link 0 is the input stage.
   logic                        stg_valid [NUM_CELLS+1];
   logic                        stg_ready [NUM_CELLS+1];
   ctl_type                     stg_ctl   [NUM_CELLS+1];
   logic [LANES-1:0][DVD_W-1:0] stg_rem   [NUM_CELLS+1];
   logic [LANES-1:0][DIV_W-1:0] stg_div   [NUM_CELLS+1];
   logic [LANES-1:0][Q_W-1:0]   stg_quo   [NUM_CELLS+1];

   // Input stage register.
   logic                        in_valid_ff;
   logic                        in_valid_in;
   ctl_type                     in_ctl_ff;
   ctl_type                     in_ctl_in;
   logic [LANES-1:0][DVD_W-1:0] in_dvd_ff;
   logic [LANES-1:0][DIV_W-1:0] in_div_ff;

   assign in_ctl_in.zero  = prep_zero;
   assign in_ctl_in.neg   = prep_neg;
   assign in_ctl_in.fault = |prep_fault;

   assign req_ready   = !in_valid_ff || stg_ready[0];
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ctl_ff <= in_ctl_in;
         in_dvd_ff <= prep_dvd;
         in_div_ff <= prep_div;
      end
   end

   assign stg_valid[0] = in_valid_ff;
   assign stg_ctl[0]   = in_ctl_ff;
   assign stg_rem[0]   = in_dvd_ff;
   assign stg_div[0]   = in_div_ff;
   assign stg_quo[0]   = '0;

   // Divider cells, most significant quotient bit first.
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      jdn_div_cell #(
         .DIV_W   (DIV_W),
         .DVD_W   (DVD_W),
         .BIT_POS (NUM_CELLS - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stg_valid[i]),
         .up_ready (stg_ready[i]),
         .up_ctl   (stg_ctl[i]),
         .up_rem   (stg_rem[i]),
         .up_div   (stg_div[i]),
         .up_quo   (stg_quo[i]),
         .dn_valid (stg_valid[i+1]),
         .dn_ready (stg_ready[i+1]),
         .dn_ctl   (stg_ctl[i+1]),
         .dn_rem   (stg_rem[i+1]),
         .dn_div   (stg_div[i+1]),
         .dn_quo   (stg_quo[i+1])
      );
   end

   // Saturation, sign and output register.
   jdn_post u_post (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (stg_valid[NUM_CELLS]),
      .up_ready       (stg_ready[NUM_CELLS]),
      .up_ctl         (stg_ctl[NUM_CELLS]),
      .up_quo         (stg_quo[NUM_CELLS]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_span_fault (rsp_span_fault)
   );

endmodule

`default_nettype wire

FILE: rtl/core/jdn_checker.sv
`default_nettype none

`include "joystick_deadzone_normalizer_unit_macros.svh"

module jdn_checker
   import jdn_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_ready,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [POS_W-1:0] rsp_pos_x,
   input  logic signed [POS_W-1:0] rsp_pos_y,
   input  logic                    rsp_span_fault
);

   localparam logic [POS_W-1:0] POS_MOST_NEG = {1'b1, {(POS_W-1){1'b0}}};

   // A stalled result item holds its valid and its payload.
   `JDN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_span_fault))

   // Saturation never lets the most negative code through.
   `JDN_ASSERT_IMPL(a_pos_range, clock, reset, rsp_valid, (rsp_pos_x != POS_MOST_NEG) && (rsp_pos_y != POS_MOST_NEG))

   // With the output free, the ready chain reaches the input.
   `JDN_ASSERT_IMPL(a_ready_chain, clock, reset, !rsp_valid || rsp_ready, req_ready)

   // Reset empties the chain; the check here is on the output register.
   `JDN_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind joystick_deadzone_normalizer_unit jdn_checker u_jdn_checker (.*);

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;
   import jdn_pkg::*;

   localparam int FULL_SCALE_CODE = 4095;
   localparam int Q_SCALE         = (1 << 15) - 1;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int TAIL_CYCLES     = 40;
   localparam int REPORT_CAP      = 100;

   // Indexes outside the register map; writes to them must be ignored.
   localparam logic [CSR_ADDR_W-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_UNMAPPED_HI = 3'd7;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic                    span_fault;
   } position_type;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_ready;
   logic [SAMPLE_W-1:0]     req_sample_x   = '0;
   logic [SAMPLE_W-1:0]     req_sample_y   = '0;
   logic                    rsp_valid;
   logic                    rsp_ready      = 1'b0;
   logic signed [POS_W-1:0] rsp_pos_x;
   logic signed [POS_W-1:0] rsp_pos_y;
   logic                    rsp_span_fault;
   logic                    csr_we         = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr       = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata      = '0;

   // Local copy of the axis settings, kept in step with every register write.
   logic [SAMPLE_W-1:0] cfg_centre_x = CENTER_RESET;
   logic [SAMPLE_W-1:0] cfg_centre_y = CENTER_RESET;
   logic [DZ_W-1:0]     cfg_dz_x     = '0;
   logic [DZ_W-1:0]     cfg_dz_y     = '0;
   logic                cfg_flip_x   = 1'b0;
   logic                cfg_flip_y   = 1'b0;

   position_type awaited_positions[$];
   int        mismatches  = 0;
   int        cycle_count = 0;
   bit        idling_on   = 1'b1;
   int        stall_left  = 0;

   joystick_deadzone_normalizer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_x   (req_sample_x),
      .req_sample_y   (req_sample_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_span_fault (rsp_span_fault),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatches < REPORT_CAP) $display("mismatch: %s", what);
      mismatches++;
   endtask

   // One axis: centre removal, deadzone, division by the span on its side,
   // clamp, then the optional sign inversion.
   function automatic logic signed [POS_W-1:0] norm_axis(
      input  logic [SAMPLE_W-1:0] code,
      input  logic [SAMPLE_W-1:0] centre,
      input  logic [DZ_W-1:0]     dz,
      input  logic                flip,
      output logic                bad
   );
      int off, num, span, mag, quot, c, d;
      bad = 1'b0;
      c = centre;
      d = dz;
      off = code;
      off = off - c;
      if (off >= -d && off <= d) return '0;
      if (off < 0) begin
         num  = off + d;
         span = c - d;
      end else begin
         num  = off - d;
         span = FULL_SCALE_CODE - c - d;
      end
      if (span <= 0) begin
         bad = 1'b1;
         return '0;
      end
      mag  = (num < 0) ? -num : num;
      quot = (mag * Q_SCALE) / span;
      if (quot > int'(POS_LIMIT)) quot = int'(POS_LIMIT);
      if (num < 0) quot = -quot;
      if (flip) quot = -quot;
      return quot[POS_W-1:0];
   endfunction

   function automatic position_type normalise_pair(input logic [SAMPLE_W-1:0] sx,
                                                   input logic [SAMPLE_W-1:0] sy);
      position_type p;
      logic         bad_x, bad_y;
      p.pos_x      = norm_axis(sx, cfg_centre_x, cfg_dz_x, cfg_flip_x, bad_x);
      p.pos_y      = norm_axis(sy, cfg_centre_y, cfg_dz_y, cfg_flip_y, bad_y);
      p.span_fault = bad_x | bad_y;
      return p;
   endfunction

   // Receiver side: random stall bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every result item is compared with the oldest outstanding prediction.
   always @(posedge clock) begin
      position_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_positions.size() == 0) begin
            report_mismatch($sformatf("result x=%0d y=%0d with nothing outstanding",
                                      rsp_pos_x, rsp_pos_y));
         end else begin
            want = awaited_positions.pop_front();
            if (rsp_pos_x !== want.pos_x)
               report_mismatch($sformatf("pos_x %0d, predicted %0d", rsp_pos_x, want.pos_x));
            if (rsp_pos_y !== want.pos_y)
               report_mismatch($sformatf("pos_y %0d, predicted %0d", rsp_pos_y, want.pos_y));
            if (rsp_span_fault !== want.span_fault)
               report_mismatch($sformatf("span_fault %b, predicted %b",
                                         rsp_span_fault, want.span_fault));
         end
      end
   end

   // Sends one sample pair, with an optional idle burst in front of it.
   task automatic send_pair(input logic [SAMPLE_W-1:0] sx, input logic [SAMPLE_W-1:0] sy);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_sample_x <= sx;
      req_sample_y <= sy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_positions.push_back(normalise_pair(sx, sy));
   endtask

   // Stops sending and waits until every predicted result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_positions.size() != 0) @(posedge clock);
   endtask

   // One register write, then a pause with the write enable low.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_CENTER_X:   cfg_centre_x = val[SAMPLE_W-1:0];
         REG_CENTER_Y:   cfg_centre_y = val[SAMPLE_W-1:0];
         REG_DEADZONE_X: cfg_dz_x     = val[DZ_W-1:0];
         REG_DEADZONE_Y: cfg_dz_y     = val[DZ_W-1:0];
         REG_FLIP_X:     cfg_flip_x   = val[0];
         REG_FLIP_Y:     cfg_flip_y   = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_axes(input logic [CSR_DATA_W-1:0] cx, input logic [CSR_DATA_W-1:0] cy,
                           input logic [CSR_DATA_W-1:0] dx, input logic [CSR_DATA_W-1:0] dy,
                           input logic [CSR_DATA_W-1:0] fx, input logic [CSR_DATA_W-1:0] fy);
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_DEADZONE_X, dx);
      write_reg(REG_DEADZONE_Y, dy);
      write_reg(REG_FLIP_X, fx);
      write_reg(REG_FLIP_Y, fy);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_centre();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return 12'd4095;
         2:       return 12'(1848 + $urandom_range(0, 400));
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   // Deadzone and flip values carry random junk above the register width.
   function automatic logic [CSR_DATA_W-1:0] pick_deadzone();
      logic [DZ_W-1:0] d;
      case ($urandom_range(0, 3))
         0:       d = '0;
         1:       d = 8'd255;
         default: d = 8'($urandom_range(0, 255));
      endcase
      return {4'($urandom_range(0, 15)), d};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_flip();
      return {11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1))};
   endfunction

   // Samples lean towards the interesting spots: the rails and the deadzone edges.
   function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] centre,
                                                      input logic [DZ_W-1:0] dz);
      int v;
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
         1: begin
            v = int'(centre) + ($urandom_range(0, 1) ? 1 : -1) *
                (int'(dz) + int'($urandom_range(0, 2)) - 1);
            if (v < 0) v = 0;
            if (v > FULL_SCALE_CODE) v = FULL_SCALE_CODE;
            return v[SAMPLE_W-1:0];
         end
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic run_random_items(input int count, input int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) wait_drained();
         send_pair(pick_sample(cfg_centre_x, cfg_dz_x), pick_sample(cfg_centre_y, cfg_dz_y));
      end
   endtask

   // Register defaults after reset: centre 2048, no deadzone, no flip.
   task automatic test_reset_defaults();
      send_pair(12'd0, 12'd4095);
      send_pair(12'd4095, 12'd0);
      send_pair(12'd2048, 12'd2048);
      send_pair(12'd2047, 12'd2049);
      send_pair(12'd2049, 12'd2047);
      wait_drained();
   endtask

   // Samples on and just past both edges of a wide deadzone.
   task automatic test_deadzone_edges();
      set_axes(12'd1000, 12'd3000, 12'd255, 12'd255, 12'd0, 12'd0);
      send_pair(12'd745, 12'd2745);
      send_pair(12'd1255, 12'd3255);
      send_pair(12'd744, 12'd2744);
      send_pair(12'd1256, 12'd3256);
      send_pair(12'd0, 12'd4095);
      send_pair(12'd4095, 12'd0);
      wait_drained();
   endtask

   // Sign inversion on both axes, including a zero result that must stay zero.
   task automatic test_flip();
      set_axes(12'd2048, 12'd1500, 12'd10, 12'd20, 12'd1, 12'd1);
      send_pair(12'd0, 12'd4095);
      send_pair(12'd4095, 12'd0);
      send_pair(12'd2050, 12'd1510);
      send_pair(12'd2100, 12'd1400);
      wait_drained();
   endtask

   // Centres at the rails, where one span collapses; a fault would need a
   // sample outside the code range, which the field cannot carry.
   task automatic test_centre_extremes();
      set_axes(12'd0, 12'd4095, 12'd0, 12'd255, 12'd0, 12'd0);
      send_pair(12'd0, 12'd4095);
      send_pair(12'd4095, 12'd0);
      wait_drained();
      write_reg(REG_DEADZONE_X, 12'd255);
      send_pair(12'd255, 12'd3840);
      send_pair(12'd256, 12'd3839);
      wait_drained();
   endtask

   // Writes to unmapped indexes leave the settings alone; high data bits are dropped.
   task automatic test_unmapped_index();
      set_axes(12'd2000, 12'd2100, 12'hF05, 12'hA0C, 12'hFFE, 12'h7FF);
      write_reg(REG_UNMAPPED_LO, 12'd0);
      write_reg(REG_UNMAPPED_HI, 12'hFFF);
      send_pair(12'd4000, 12'd100);
      send_pair(12'd2004, 12'd2113);
      wait_drained();
   endtask

   // Several random settings with idling on both sides and one full drain
   // partway through.
   task automatic test_random_mix();
      for (int phase = 0; phase < 5; phase++) begin
         set_axes(pick_centre(), pick_centre(), pick_deadzone(), pick_deadzone(),
                  pick_flip(), pick_flip());
         run_random_items(90, (phase == 2) ? 45 : -1);
         wait_drained();
      end
   endtask

   // Back-to-back items with no idling on either side.
   task automatic test_steady_stream();
      idling_on = 1'b0;
      set_axes(pick_centre(), pick_centre(), pick_deadzone(), pick_deadzone(),
               pick_flip(), pick_flip());
      run_random_items(60, -1);
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_deadzone_edges();
      test_flip();
      test_centre_extremes();
      test_unmapped_index();
      test_random_mix();
      test_steady_stream();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_positions.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", awaited_positions.size()));
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/jdn_pkg.sv
rtl/core/jdn_prep.sv
rtl/core/jdn_div_cell.sv
rtl/core/jdn_post.sv
rtl/core/joystick_deadzone_normalizer_unit.sv
rtl/core/jdn_checker.sv
tb/sv/tb.sv
